[hw/rtl/sparse_voxel_neighbor_map_core_macros.svh]
// Assertion macros shared by the kernel map RTL.
// Each macro expects aclk and aresetn in the scope where it is used.
`ifndef SPARSE_VOXEL_NEIGHBOR_MAP_CORE_MACROS_SVH
`define SPARSE_VOXEL_NEIGHBOR_MAP_CORE_MACROS_SVH

// Same-cycle implication.
`define SVNM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SVNM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/svnm_pkg.sv]
package svnm_pkg;

    localparam int MAX_VOXELS = 65536;
    localparam int HASH_SLOTS = 131072;
    localparam int COORD_BITS = 20;
    localparam int TAPS       = 27;

    localparam int FIELD_W  = 20;
    localparam int KEY_W    = 3 * FIELD_W;
    localparam int IDX_W    = 16;
    localparam int NIDX_W   = 17;
    localparam int TAP_W    = 5;
    localparam int STATUS_W = 2;
    localparam int CMD_W    = 2;
    localparam int VOX_W    = $clog2(MAX_VOXELS);
    localparam int CNT_W    = VOX_W + 1;
    localparam int SLOT_W   = $clog2(HASH_SLOTS);

    // The hash keeps the low HASH_W bits of the product, which covers the
    // xor-fold for tables of up to 2^21 slots.
    localparam int HASH_SHIFT = 29;
    localparam int HASH_W     = 50;
    localparam int HASH_HALF  = HASH_W / 2;
    localparam int HASH_YW    = HASH_W - FIELD_W;
    localparam int HASH_XW    = HASH_W - 2 * FIELD_W;
    localparam logic [63:0] HASH_MUL = 64'h9E37_79B9_7F4A_7C15;

    localparam logic [FIELD_W-1:0] COORD_MASK =
        FIELD_W'((64'd1 << COORD_BITS) - 64'd1);
    localparam logic [FIELD_W:0] COORD_SPAN = (FIELD_W + 1)'(64'd1 << COORD_BITS);

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_STORED = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [FIELD_W-1:0] coord_x;
        logic [FIELD_W-1:0] coord_y;
        logic [FIELD_W-1:0] coord_z;
        logic [IDX_W-1:0]   voxel_index;
    } in_item_t;

    typedef struct packed {
        logic [TAP_W-1:0]    tap;
        logic [NIDX_W-1:0]   neighbor_index;
        logic                last;
        logic [STATUS_W-1:0] status;
    } out_item_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VOX_W-1:0] voxel;
    } slot_entry_t;

    function automatic logic [KEY_W-1:0] pack_key(input logic [FIELD_W-1:0] x,
                                                  input logic [FIELD_W-1:0] y,
                                                  input logic [FIELD_W-1:0] z);
        return {x, y, z};
    endfunction

    function automatic out_item_t mk_result(input logic [TAP_W-1:0]    tap,
                                            input logic [NIDX_W-1:0]   idx,
                                            input logic                last,
                                            input logic [STATUS_W-1:0] status);
        out_item_t r;
        r.tap            = tap;
        r.neighbor_index = idx;
        r.last           = last;
        r.status         = status;
        return r;
    endfunction

endpackage

[hw/rtl/svnm_ram.sv]
module svnm_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/svnm_hash.sv]
module svnm_hash import svnm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [KEY_W-1:0]  in_key,
    output logic              out_valid,
    output logic [SLOT_W-1:0] out_slot
);

    // Only the low HASH_W bits of key * HASH_MUL matter, so the product is
    // built from four narrow partial products: two for z, one each for y and x.
    logic [FIELD_W-1:0] x;
    logic [FIELD_W-1:0] y;
    logic [FIELD_W-1:0] z;

    logic [FIELD_W+HASH_HALF-1:0] pz_lo_next, pz_lo_reg;
    logic [HASH_W-HASH_HALF-1:0]  pz_hi_next, pz_hi_reg;
    logic [HASH_YW-1:0]           py_next, py_reg;
    logic [HASH_XW-1:0]           px_next, px_reg;
    logic [HASH_W-1:0]            h;
    logic [SLOT_W-1:0]            slot_next, slot_reg;
    logic                         v1_reg, v2_reg;

    assign x = in_key[KEY_W-1 -: FIELD_W];
    assign y = in_key[KEY_W-FIELD_W-1 -: FIELD_W];
    assign z = in_key[FIELD_W-1:0];

    assign pz_lo_next = (FIELD_W + HASH_HALF)'(z)
                      * (FIELD_W + HASH_HALF)'(HASH_MUL[HASH_HALF-1:0]);
    assign pz_hi_next = (HASH_W - HASH_HALF)'(z) * HASH_MUL[HASH_W-1:HASH_HALF];
    assign py_next    = HASH_YW'(y) * HASH_MUL[HASH_YW-1:0];
    assign px_next    = x[HASH_XW-1:0] * HASH_MUL[HASH_XW-1:0];

    assign h = HASH_W'(pz_lo_reg)
             + {pz_hi_reg, {HASH_HALF{1'b0}}}
             + {py_reg, {FIELD_W{1'b0}}}
             + {px_reg, {(2 * FIELD_W){1'b0}}};

    assign slot_next = h[SLOT_W-1:0] ^ h[HASH_SHIFT +: SLOT_W];

    always_ff @(posedge aclk) begin
        pz_lo_reg <= pz_lo_next;
        pz_hi_reg <= pz_hi_next;
        py_reg    <= py_next;
        px_reg    <= px_next;
        slot_reg  <= slot_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_slot  = slot_reg;

endmodule

[hw/rtl/sparse_voxel_neighbor_map_core.sv]
// Sparse voxel kernel map builder. A clear transfer empties the set, an
// insert transfer stores a coordinate under the next voxel index and returns
// that index, and a query transfer returns the 27 neighbor indices of a
// stored voxel in tap order (tap = dx*9 + dy*3 + dz, dz moving fastest),
// with the voxel count standing for an absent neighbor. Every input transfer
// except a no-operation yields one result, a valid query yields 27.
// Coordinates live in a linear-probed hash table held in one
// single-port-per-side synchronous RAM of HASH_SLOTS entries, and each
// voxel's coordinate in a second RAM of MAX_VOXELS entries. One item is
// worked at a time. The slot RAM read of each probe overlaps the compare
// of the slot read before it; a tap outside the coordinate range skips the
// lookup, and a stalled output holds the item in S_EMIT. After reset and
// after each clear command the slot RAM is swept, one entry per cycle,
// across all HASH_SLOTS entries, and no input transfer is taken meanwhile.
`include "sparse_voxel_neighbor_map_core_macros.svh"

module sparse_voxel_neighbor_map_core import svnm_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_QRD   = 8'b0000_0100,
        S_TAP   = 8'b0000_1000,
        S_HASH  = 8'b0001_0000,
        S_PCHK  = 8'b0010_0000,
        S_EMIT  = 8'b0100_0000,
        S_SPARE = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic               is_query_reg, is_query_next;
    logic [FIELD_W-1:0] base_x_reg, base_x_next;
    logic [FIELD_W-1:0] base_y_reg, base_y_next;
    logic [FIELD_W-1:0] base_z_reg, base_z_next;
    logic [1:0]         dig_a_reg, dig_a_next;
    logic [1:0]         dig_b_reg, dig_b_next;
    logic [1:0]         dig_c_reg, dig_c_next;
    logic [TAP_W-1:0]   tap_reg, tap_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [SLOT_W-1:0]  probe_cnt_reg, probe_cnt_next;
    logic [SLOT_W-1:0]  clr_addr_reg, clr_addr_next;
    logic               clr_emit_reg, clr_emit_next;
    logic               more_reg, more_next;
    out_item_t          res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg, m_data_next;

    // Slot table and voxel coordinate RAM ports.
    logic                      slot_we, slot_re;
    logic [SLOT_W-1:0]         slot_waddr, slot_raddr;
    slot_entry_t               slot_wdata, slot_entry;
    logic [$bits(slot_entry_t)-1:0] slot_rdata;
    logic                      coord_we, coord_re;
    logic [VOX_W-1:0]          coord_waddr, coord_raddr;
    logic [KEY_W-1:0]          coord_wdata, coord_rdata;

    logic               h_start, h_valid;
    logic [SLOT_W-1:0]  h_slot;

    logic [KEY_W-1:0]   in_key;
    logic [FIELD_W:0]   nx_ext, ny_ext, nz_ext;
    logic               outside;
    logic [KEY_W-1:0]   n_key;
    logic               tap_last;
    logic               hit, free;

    svnm_ram #(
        .DEPTH (HASH_SLOTS),
        .WIDTH ($bits(slot_entry_t))
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (slot_re),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    svnm_ram #(
        .DEPTH (MAX_VOXELS),
        .WIDTH (KEY_W)
    ) u_coord_ram (
        .aclk  (aclk),
        .we    (coord_we),
        .waddr (coord_waddr),
        .wdata (coord_wdata),
        .re    (coord_re),
        .raddr (coord_raddr),
        .rdata (coord_rdata)
    );

    svnm_hash u_hash (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (h_start),
        .in_key    (key_next),
        .out_valid (h_valid),
        .out_slot  (h_slot)
    );

    assign slot_entry = slot_entry_t'(slot_rdata);
    assign hit        = slot_entry.valid && (slot_entry.key == key_reg);
    assign free       = !slot_entry.valid;

    assign in_key = pack_key(s_data.coord_x & COORD_MASK,
                             s_data.coord_y & COORD_MASK,
                             s_data.coord_z & COORD_MASK);

    // Neighbor coordinates carry one extra bit and an offset of +1, so that
    // zero means "one below the range" and anything above the span means
    // "one above the range".
    assign nx_ext  = {1'b0, base_x_reg} + (FIELD_W + 1)'(dig_a_reg);
    assign ny_ext  = {1'b0, base_y_reg} + (FIELD_W + 1)'(dig_b_reg);
    assign nz_ext  = {1'b0, base_z_reg} + (FIELD_W + 1)'(dig_c_reg);
    assign outside = (nx_ext == '0) || (nx_ext > COORD_SPAN)
                  || (ny_ext == '0) || (ny_ext > COORD_SPAN)
                  || (nz_ext == '0) || (nz_ext > COORD_SPAN);
    assign n_key   = pack_key(FIELD_W'(nx_ext - 1'b1),
                              FIELD_W'(ny_ext - 1'b1),
                              FIELD_W'(nz_ext - 1'b1));
    assign tap_last = (tap_reg == TAP_W'(TAPS - 1));

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        key_next       = key_reg;
        is_query_next  = is_query_reg;
        base_x_next    = base_x_reg;
        base_y_next    = base_y_reg;
        base_z_next    = base_z_reg;
        dig_a_next     = dig_a_reg;
        dig_b_next     = dig_b_reg;
        dig_c_next     = dig_c_reg;
        tap_next       = tap_reg;
        slot_next      = slot_reg;
        probe_cnt_next = probe_cnt_reg;
        clr_addr_next  = clr_addr_reg;
        clr_emit_next  = clr_emit_reg;
        more_next      = more_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        s_ready        = 1'b0;
        slot_we        = 1'b0;
        slot_waddr     = slot_reg;
        slot_wdata     = '0;
        slot_re        = 1'b0;
        slot_raddr     = slot_reg;
        coord_we       = 1'b0;
        coord_waddr    = count_reg[VOX_W-1:0];
        coord_wdata    = key_reg;
        coord_re       = 1'b0;
        coord_raddr    = VOX_W'(s_data.voxel_index);
        h_start        = 1'b0;

        unique case (state_reg)
            // Sweep every slot to invalid; a clear command reports at the end.
            S_CLEAR: begin
                slot_we       = 1'b1;
                slot_waddr    = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == SLOT_W'(HASH_SLOTS - 1)) begin
                    if (clr_emit_reg) begin
                        res_next   = mk_result('0, '0, 1'b1, ST_OK);
                        more_next  = 1'b0;
                        state_next = S_EMIT;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    unique case (s_data.cmd)
                        CMD_CLEAR: begin
                            count_next    = '0;
                            clr_addr_next = '0;
                            clr_emit_next = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        CMD_INSERT: begin
                            is_query_next = 1'b0;
                            more_next     = 1'b0;
                            if (count_reg >= CNT_W'(MAX_VOXELS)) begin
                                res_next   = mk_result('0, NIDX_W'(count_reg), 1'b1,
                                                       ST_FULL);
                                state_next = S_EMIT;
                            end else begin
                                key_next   = in_key;
                                h_start    = 1'b1;
                                state_next = S_HASH;
                            end
                        end
                        CMD_QUERY: begin
                            is_query_next = 1'b1;
                            if (CNT_W'(s_data.voxel_index) >= count_reg) begin
                                res_next   = mk_result('0, NIDX_W'(count_reg), 1'b1,
                                                       ST_NOT_STORED);
                                more_next  = 1'b0;
                                state_next = S_EMIT;
                            end else begin
                                coord_re   = 1'b1;
                                state_next = S_QRD;
                            end
                        end
                        CMD_NOP: begin
                            state_next = S_IDLE;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // The center coordinate arrives from the coordinate RAM.
            S_QRD: begin
                base_x_next = coord_rdata[KEY_W-1 -: FIELD_W];
                base_y_next = coord_rdata[KEY_W-FIELD_W-1 -: FIELD_W];
                base_z_next = coord_rdata[FIELD_W-1:0];
                dig_a_next  = '0;
                dig_b_next  = '0;
                dig_c_next  = '0;
                tap_next    = '0;
                state_next  = S_TAP;
            end

            S_TAP: begin
                if (outside) begin
                    res_next   = mk_result(tap_reg, NIDX_W'(count_reg), tap_last, ST_OK);
                    more_next  = !tap_last;
                    state_next = S_EMIT;
                end else begin
                    key_next   = n_key;
                    h_start    = 1'b1;
                    state_next = S_HASH;
                end
            end

            S_HASH: begin
                if (h_valid) begin
                    slot_re        = 1'b1;
                    slot_raddr     = h_slot;
                    slot_next      = h_slot;
                    probe_cnt_next = '0;
                    state_next     = S_PCHK;
                end
            end

            // One probe per cycle: the slot read last cycle is checked while
            // the following slot is already being read. Nothing is written
            // until the probe ends, so no read can see a stale entry.
            S_PCHK: begin
                if (hit || free) begin
                    if (is_query_reg) begin
                        res_next  = mk_result(tap_reg,
                                              hit ? NIDX_W'(slot_entry.voxel)
                                                  : NIDX_W'(count_reg),
                                              tap_last, ST_OK);
                        more_next = !tap_last;
                    end else begin
                        slot_we          = 1'b1;
                        slot_wdata.valid = 1'b1;
                        slot_wdata.key   = key_reg;
                        slot_wdata.voxel = count_reg[VOX_W-1:0];
                        coord_we         = 1'b1;
                        res_next   = mk_result('0, NIDX_W'(count_reg), 1'b1, ST_OK);
                        more_next  = 1'b0;
                        count_next = count_reg + 1'b1;
                    end
                    state_next = S_EMIT;
                end else if (probe_cnt_reg == SLOT_W'(HASH_SLOTS - 1)) begin
                    // Every slot is taken by another key.
                    if (is_query_reg) begin
                        res_next  = mk_result(tap_reg, NIDX_W'(count_reg), tap_last, ST_OK);
                        more_next = !tap_last;
                    end else begin
                        res_next  = mk_result('0, NIDX_W'(count_reg), 1'b1, ST_FULL);
                        more_next = 1'b0;
                    end
                    state_next = S_EMIT;
                end else begin
                    slot_next      = slot_reg + 1'b1;
                    probe_cnt_next = probe_cnt_reg + 1'b1;
                    slot_re        = 1'b1;
                    slot_raddr     = slot_reg + 1'b1;
                end
            end

            // Hand the result to the output register once it is free.
            S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    if (more_reg) begin
                        tap_next   = tap_reg + 1'b1;
                        state_next = S_TAP;
                        if (dig_c_reg == 2'd2) begin
                            dig_c_next = '0;
                            if (dig_b_reg == 2'd2) begin
                                dig_b_next = '0;
                                dig_a_next = dig_a_reg + 1'b1;
                            end else begin
                                dig_b_next = dig_b_reg + 1'b1;
                            end
                        end else begin
                            dig_c_next = dig_c_reg + 1'b1;
                        end
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            count_reg     <= '0;
            clr_addr_reg  <= '0;
            clr_emit_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            is_query_reg  <= 1'b0;
            more_reg      <= 1'b0;
            tap_reg       <= '0;
            dig_a_reg     <= '0;
            dig_b_reg     <= '0;
            dig_c_reg     <= '0;
            probe_cnt_reg <= '0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            clr_addr_reg  <= clr_addr_next;
            clr_emit_reg  <= clr_emit_next;
            m_valid_reg   <= m_valid_next;
            is_query_reg  <= is_query_next;
            more_reg      <= more_next;
            tap_reg       <= tap_next;
            dig_a_reg     <= dig_a_next;
            dig_b_reg     <= dig_b_next;
            dig_c_reg     <= dig_c_next;
            probe_cnt_reg <= probe_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg    <= key_next;
        base_x_reg <= base_x_next;
        base_y_reg <= base_y_next;
        base_z_reg <= base_z_next;
        slot_reg   <= slot_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `SVNM_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_VOXELS), "voxel count overflow")
    `SVNM_ASSERT_IMPL(a_error_is_last, m_valid && (m_data.status != ST_OK), m_data.last, "error result not last")
    `SVNM_ASSERT_IMPL(a_tap_last, m_valid && (m_data.tap != '0), m_data.last == (m_data.tap == TAP_W'(TAPS - 1)), "last flag does not match tap")
    `SVNM_ASSERT_NEXT(a_insert_count, (state_reg == S_PCHK) && !is_query_reg && (hit || free), count_reg == $past(count_reg) + CNT_W'(1), "insert did not advance count")

endmodule
